// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker in rtl/lla_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define LLA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LLA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lla_pkg.sv =====
package lla_pkg;

  // Fixed field widths of the ports
  localparam int KIND_W     = 2;
  localparam int ROW_FLD_W  = 6;
  localparam int COL_FLD_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int USED_W     = 7;
  localparam int MASK_W     = 9;
  localparam int NCNT_W     = 4;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MASK = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;

  typedef struct packed {
    logic [MASK_W-1:0] birth_mask;
    logic [MASK_W-1:0] survive_mask;
  } rule_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_GEN_UP,
    ST_GEN_MID,
    ST_GEN_LOAD,
    ST_GEN_ROW
  } lla_state_t;

endpackage

// ===== rtl/lla_grid_mem.sv =====
module lla_grid_mem #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [COLS-1:0]         wr_data,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [COLS-1:0]         rd_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [COLS-1:0] rd_word_r;
  logic            rd_vld_r;

  // Grid rows; one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // A row never written since reset reads as all dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

// ===== rtl/lla_row_update.sv =====
module lla_row_update #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]           up_row,
  input  logic [COLS-1:0]           mid_row,
  input  logic [COLS-1:0]           down_row,
  input  logic [$clog2(COLS+1)-1:0] ncols,
  input  lla_pkg::rule_t            rule,
  output logic [COLS-1:0]           new_row
);

  import lla_pkg::*;

  localparam int COL_W  = $clog2(COLS);
  localparam int CCNT_W = $clog2(COLS + 1);

  logic [COL_W-1:0] last_col;
  logic             up_last, mid_last, down_last;

  assign last_col  = COL_W'(ncols - 1'b1);
  assign up_last   = up_row[last_col];
  assign mid_last  = mid_row[last_col];
  assign down_last = down_row[last_col];

  for (genvar c = 0; c < COLS; c++) begin : g_col
    localparam int LI = (c == 0) ? COLS - 1 : c - 1;
    localparam int RI = (c == COLS - 1) ? 0 : c + 1;

    logic              at_last;
    logic              ul, ml, dl, ur, mr, dr;
    logic [NCNT_W-1:0] cnt;
    logic              born_or_kept;

    assign at_last = (COL_W'(c) == last_col);

    // Wrap left of column 0 to the last used column, and right of the last used column to column 0
    assign ul = (c == 0) ? up_last   : up_row[LI];
    assign ml = (c == 0) ? mid_last  : mid_row[LI];
    assign dl = (c == 0) ? down_last : down_row[LI];
    assign ur = at_last ? up_row[0]   : up_row[RI];
    assign mr = at_last ? mid_row[0]  : mid_row[RI];
    assign dr = at_last ? down_row[0] : down_row[RI];

    assign cnt = NCNT_W'(ul) + NCNT_W'(up_row[c]) + NCNT_W'(ur)
               + NCNT_W'(ml) + NCNT_W'(mr)
               + NCNT_W'(dl) + NCNT_W'(down_row[c]) + NCNT_W'(dr);

    assign born_or_kept = mid_row[c] ? rule.survive_mask[cnt] : rule.birth_mask[cnt];

    // Hold columns outside the used area
    assign new_row[c] = (CCNT_W'(c) < ncols) ? born_or_kept : mid_row[c];
  end

endmodule

// ===== rtl/life_like_automaton_step.sv =====
// Life-like automaton on a wrapping grid of one-bit cells, held one row per word in a
// single synchronous grid memory. Each transaction on the input channel writes a cell,
// reads a cell or advances one generation; only a read gives a result transaction.
// One item is worked on at a time: a write reads the row, then writes it back; a read
// waits for the row read and, while a result is held, for out_ready; a generation
// reads the last row and row 0 into a row window of three rows that slides down the
// grid with one row read and one row write a cycle. Rows update in place; the old
// first row is held in a register for the wrap of the last row. Reset clears the grid
// at once through one valid bit per row, so no clearing pass follows reset.
// Configuration writes are always taken and must only be made while the block is idle.
module life_like_automaton_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lla_pkg::KIND_W-1:0]    in_kind,
  input  logic [lla_pkg::ROW_FLD_W-1:0] in_row,
  input  logic [lla_pkg::COL_FLD_W-1:0] in_column,
  input  logic                          in_write_alive,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_cell_alive,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lla_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int RX_W   = (RCNT_W > USED_W) ? RCNT_W : USED_W;
  localparam int CX_W   = (CCNT_W > USED_W) ? CCNT_W : USED_W;

  // configuration registers
  logic [USED_W-1:0] rows_used_r, cols_used_r;
  logic [MASK_W-1:0] birth_mask_r, survive_mask_r;
  rule_t             rule;

  // control
  lla_state_t        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_alive_r, out_alive_nxt;
  logic [ROW_W-1:0]  gen_row_r, gen_row_nxt;

  // item held while it is worked on
  logic [ROW_W-1:0]  item_row_r;
  logic [COL_W-1:0]  item_col_r;
  logic              item_wval_r;
  logic              item_inside_r;
  logic              item_load;

  // row window
  logic [MAX_COLS-1:0] up_r, up_nxt;
  logic [MAX_COLS-1:0] mid_r, mid_nxt;
  logic [MAX_COLS-1:0] row0_r, row0_nxt;
  logic [MAX_COLS-1:0] down_row, new_row, patched_row;

  // grid memory access
  logic                wr_en, rd_en;
  logic [ROW_W-1:0]    wr_addr, rd_addr;
  logic [MAX_COLS-1:0] wr_data, rd_data;

  // clamped sizes
  logic [RX_W-1:0]   rows_x, eff_rows_x;
  logic [CX_W-1:0]   cols_x, eff_cols_x;
  logic [RCNT_W-1:0] eff_rows;
  logic [CCNT_W-1:0] eff_cols;
  logic [ROW_W-1:0]  last_row;
  logic              is_last;
  logic [RCNT_W:0]   row_ahead;
  logic              in_inside;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, takes the low bits of the data per register
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r    <= USED_W'(64);
      cols_used_r    <= USED_W'(64);
      birth_mask_r   <= BIRTH_RST;
      survive_mask_r <= SURVIVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_USED:    rows_used_r    <= cfg_data[USED_W-1:0];
        CFG_COLS_USED:    cols_used_r    <= cfg_data[USED_W-1:0];
        CFG_BIRTH_MASK:   birth_mask_r   <= cfg_data[MASK_W-1:0];
        CFG_SURVIVE_MASK: survive_mask_r <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign rule.birth_mask   = birth_mask_r;
  assign rule.survive_mask = survive_mask_r;

  // Clamp the used sizes: zero counts as one, and above the maximum as the maximum
  always_comb begin
    rows_x = RX_W'(rows_used_r);
    cols_x = CX_W'(cols_used_r);
    priority if (rows_x == '0)              eff_rows_x = RX_W'(1);
    else if (rows_x > RX_W'(MAX_ROWS))      eff_rows_x = RX_W'(MAX_ROWS);
    else                                    eff_rows_x = rows_x;
    priority if (cols_x == '0)              eff_cols_x = CX_W'(1);
    else if (cols_x > CX_W'(MAX_COLS))      eff_cols_x = CX_W'(MAX_COLS);
    else                                    eff_cols_x = cols_x;
  end

  assign eff_rows  = RCNT_W'(eff_rows_x);
  assign eff_cols  = CCNT_W'(eff_cols_x);
  assign last_row  = ROW_W'(eff_rows - 1'b1);
  assign is_last   = (gen_row_r == last_row);
  assign row_ahead = (RCNT_W + 1)'(gen_row_r) + (RCNT_W + 1)'(2);

  assign in_inside = (RX_W'(in_row) < eff_rows_x) && (CX_W'(in_column) < eff_cols_x);

  // ---------------------------------------------------------------------------
  // Grid memory and next-row logic
  // ---------------------------------------------------------------------------
  lla_grid_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Below the last row the next row comes from memory; the last row wraps to old row 0
  assign down_row = is_last ? row0_r : rd_data;

  lla_row_update #(
    .COLS (MAX_COLS)
  ) u_upd (
    .up_row   (up_r),
    .mid_row  (mid_r),
    .down_row (down_row),
    .ncols    (eff_cols),
    .rule     (rule),
    .new_row  (new_row)
  );

  // Row with the written cell replaced
  always_comb begin
    patched_row             = rd_data;
    patched_row[item_col_r] = item_wval_r;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);
  assign item_load = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    gen_row_nxt   = gen_row_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    row0_nxt      = row0_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_alive_nxt = out_alive_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = new_row;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_WRITE: begin
              // drop writes outside the used area
              if (in_inside) begin
                rd_en     = 1'b1;
                rd_addr   = ROW_W'(in_row);
                state_nxt = ST_WR;
              end
            end
            KIND_READ: begin
              rd_en     = in_inside;
              rd_addr   = ROW_W'(in_row);
              state_nxt = ST_RD;
            end
            KIND_STEP: begin
              state_nxt = ST_GEN_UP;
            end
            default: ;
          endcase
        end
      end
      ST_WR: begin
        wr_en     = 1'b1;
        wr_addr   = item_row_r;
        wr_data   = patched_row;
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_alive_nxt = item_inside_r && rd_data[item_col_r];
          state_nxt     = ST_IDLE;
        end
      end
      ST_GEN_UP: begin
        rd_en     = 1'b1;
        rd_addr   = last_row;
        state_nxt = ST_GEN_MID;
      end
      ST_GEN_MID: begin
        up_nxt    = rd_data;
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = ST_GEN_LOAD;
      end
      ST_GEN_LOAD: begin
        mid_nxt     = rd_data;
        row0_nxt    = rd_data;
        gen_row_nxt = '0;
        rd_en       = (eff_rows > RCNT_W'(1));
        rd_addr     = ROW_W'(1);
        state_nxt   = ST_GEN_ROW;
      end
      ST_GEN_ROW: begin
        // write the new row in place and slide the window down
        wr_en   = 1'b1;
        wr_addr = gen_row_r;
        up_nxt  = mid_r;
        mid_nxt = down_row;
        if (is_last) begin
          state_nxt = ST_IDLE;
        end else begin
          gen_row_nxt = gen_row_r + 1'b1;
          rd_en       = (row_ahead < (RCNT_W + 1)'(eff_rows));
          rd_addr     = ROW_W'(row_ahead);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gen_row_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gen_row_r   <= gen_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_alive_r <= out_alive_nxt;
    up_r        <= up_nxt;
    mid_r       <= mid_nxt;
    row0_r      <= row0_nxt;
    if (item_load) begin
      item_row_r    <= ROW_W'(in_row);
      item_col_r    <= COL_W'(in_column);
      item_wval_r   <= in_write_alive;
      item_inside_r <= in_inside;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_alive_r;

endmodule

// ===== rtl/lla_checker.sv =====
`include "assert_macros.svh"

module lla_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [lla_pkg::KIND_W-1:0]     in_kind,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_cell_alive
);

  import lla_pkg::*;

  logic busy_kind;
  assign busy_kind = (in_kind == KIND_READ) || (in_kind == KIND_STEP);

  // a stalled result holds
  `LLA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_cell_alive), "result changed while stalled")

  // a read or a generation keeps the item side busy in the next cycle
  `LLA_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready && busy_kind |=> !in_ready, "ready straight after a read or generation")

  // a new result is only produced while an item is being worked on
  `LLA_ASSERT(a_result_from_item, clk, rst_n, $rose(out_valid) |-> !$past(in_ready), "result appeared while idle")

  // reset drops any pending result
  `LLA_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind life_like_automaton_step lla_checker u_lla_checker (.*);

// ===== tb/sv/life_like_automaton_step_checker.sv =====
`timescale 1ns / 100ps

module life_like_automaton_step_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [lla_pkg::KIND_W-1:0]     in_kind,
  input  logic [lla_pkg::ROW_FLD_W-1:0]  in_row,
  input  logic [lla_pkg::COL_FLD_W-1:0]  in_column,
  input  logic                           in_write_alive,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_cell_alive,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             reads_outstanding
);

  import lla_pkg::*;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;

  logic [GRID_COLS-1:0] live_cells [GRID_ROWS];
  logic [USED_W-1:0]    rows_reg;
  logic [USED_W-1:0]    cols_reg;
  logic [MASK_W-1:0]    birth_reg;
  logic [MASK_W-1:0]    survive_reg;
  logic                 cell_reads_due [$];
  int                   errors = 0;
  int                   outstanding = 0;

  assign mismatch_count    = errors;
  assign reads_outstanding = outstanding;

  function automatic int unsigned clamp_extent(input logic [USED_W-1:0] used, input int limit);
    if (used == 0) return 1;
    if (used > limit) return limit;
    return used;
  endfunction

  // Wrapped neighbour count; on tiny grids one cell may be hit more than once.
  function automatic int unsigned live_neighbours(input int unsigned r, c, nr, nc);
    int unsigned total;
    total = 0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (!(dr == 1 && dc == 1))
          total += live_cells[(r + nr + dr - 1) % nr][(c + nc + dc - 1) % nc];
      end
    end
    return total;
  endfunction

  task automatic advance_generation();
    logic [GRID_COLS-1:0] next_cells [GRID_ROWS];
    logic [MASK_W-1:0]    rule;
    int unsigned          nr;
    int unsigned          nc;
    int unsigned          n;
    nr = clamp_extent(rows_reg, GRID_ROWS);
    nc = clamp_extent(cols_reg, GRID_COLS);
    next_cells = live_cells;
    for (int unsigned r = 0; r < nr; r++) begin
      for (int unsigned c = 0; c < nc; c++) begin
        n = live_neighbours(r, c, nr, nc);
        rule = live_cells[r][c] ? survive_reg : birth_reg;
        next_cells[r][c] = rule[n];
      end
    end
    live_cells = next_cells;
  endtask

  task automatic report_mismatch(input string note);
    $display("%0t ns: mismatch: %s", $time, note);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (live_cells[r]) live_cells[r] = '0;
      rows_reg    = USED_W'(GRID_ROWS);
      cols_reg    = USED_W'(GRID_COLS);
      birth_reg   = BIRTH_RST;
      survive_reg = SURVIVE_RST;
      cell_reads_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cell_reads_due.size() == 0) begin
          report_mismatch($sformatf("cell_alive %b with no read outstanding", out_cell_alive));
        end else if (out_cell_alive !== cell_reads_due[0]) begin
          report_mismatch($sformatf("cell_alive expected %b got %b",
                                    cell_reads_due[0], out_cell_alive));
          void'(cell_reads_due.pop_front());
        end else begin
          void'(cell_reads_due.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS_USED:    rows_reg    = cfg_data[USED_W-1:0];
          CFG_COLS_USED:    cols_reg    = cfg_data[USED_W-1:0];
          CFG_BIRTH_MASK:   birth_reg   = cfg_data[MASK_W-1:0];
          CFG_SURVIVE_MASK: survive_reg = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_kind)
          KIND_WRITE: begin
            if (in_row < clamp_extent(rows_reg, GRID_ROWS) &&
                in_column < clamp_extent(cols_reg, GRID_COLS))
              live_cells[in_row][in_column] = in_write_alive;
          end
          KIND_READ: begin
            if (in_row < clamp_extent(rows_reg, GRID_ROWS) &&
                in_column < clamp_extent(cols_reg, GRID_COLS))
              cell_reads_due.push_back(live_cells[in_row][in_column]);
            else
              cell_reads_due.push_back(1'b0);
          end
          KIND_STEP: advance_generation();
          default: ;
        endcase
      end
    end
    outstanding = cell_reads_due.size();
  end

endmodule

// ===== tb/sv/life_like_automaton_step_tb.sv =====
`timescale 1ns / 100ps

module life_like_automaton_step_tb;

  import lla_pkg::*;

  // Spare kind encoding: the block must take it and do nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Longest generation runs over all 64 rows; leave margin before touching config
  localparam int SETTLE_CYCLES    = 80;
  // Long stalls on the result side, requested in some phases, to back the block up
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int PHASES           = 14;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind        = KIND_WRITE;
  logic [ROW_FLD_W-1:0]  in_row         = '0;
  logic [COL_FLD_W-1:0]  in_column      = '0;
  logic                  in_write_alive = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  out_cell_alive;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = CFG_ROWS_USED;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  int mismatch_count;
  int reads_outstanding;
  // Bumped by the stimulus thread at a rising edge; the sink picks it up at a falling edge
  int hold_requests = 0;
  int burst_left    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  life_like_automaton_step u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_write_alive (in_write_alive),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  life_like_automaton_step_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_row            (in_row),
    .in_column         (in_column),
    .in_write_alive    (in_write_alive),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cell_alive    (out_cell_alive),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .reads_outstanding (reads_outstanding)
  );

  // Clamp a rows/cols register value the way the block does: 0 acts as 1, above 64 as 64
  function automatic int unsigned grid_extent(input logic [CFG_DATA_W-1:0] data);
    if (data[USED_W-1:0] == 0) return 1;
    if (data[USED_W-1:0] > 64) return 64;
    return data[USED_W-1:0];
  endfunction

  // Offer one item transaction. Items go out in bursts; a burst boundary drops
  // valid for a random gap (sometimes none). Return at the accepting rising edge,
  // so valid stays up if the next call follows straight on.
  task automatic issue_op(input logic [KIND_W-1:0] kind, input int unsigned row, col,
                          input logic alive);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_row         <= row[ROW_FLD_W-1:0];
    in_column      <= col[COL_FLD_W-1:0];
    in_write_alive <= alive;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold the sender until every read has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reads_outstanding != 0) @(negedge clk);
  endtask

  // Writes and generations give no result, so let a possible generation finish too
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a rule pair: one of the named rule sets or a random mask pair
  task automatic pick_rule(output logic [CFG_DATA_W-1:0] birth, survive);
    case ($urandom_range(0, 4))
      0: begin birth = 9'd8;   survive = 9'd12; end   // B3/S23
      1: begin birth = 9'd496; survive = 9'd60;  end  // walled cities
      2: begin birth = 9'd2;   survive = 9'd2;   end  // gnarl
      3: begin birth = 9'd24;  survive = 9'd24;  end  // 34 life
      default: begin
        birth   = CFG_DATA_W'($urandom_range(0, 511));
        survive = CFG_DATA_W'($urandom_range(0, 511));
      end
    endcase
  endtask

  // Result sink: stall on a pattern of its own, plus one long hold-off on request
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int holds_served;
    int tick;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    holds_served = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 120);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;                          // no stalls at all
          1: out_ready <= 1'($urandom_range(0, 1));      // coin toss
          2: out_ready <= ($urandom_range(0, 4) == 0);   // mostly stalled
          default: out_ready <= (tick % 3 == 0);         // ready when tick is a multiple of three
        endcase
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] rows_data;
    logic [CFG_DATA_W-1:0] cols_data;
    logic [CFG_DATA_W-1:0] birth_data;
    logic [CFG_DATA_W-1:0] survive_data;
    int unsigned           nr;
    int unsigned           nc;
    int                    items_left;
    int                    pick;
    int unsigned           r;
    int unsigned           c;

    // Hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: default 64x64 grid with B3/S23 after reset.
    // Corner cells at both field extremes, write-back of dead, ignored spare kind.
    issue_op(KIND_WRITE, 0, 0, 1'b1);
    issue_op(KIND_WRITE, 63, 63, 1'b1);
    issue_op(KIND_READ, 0, 0, 1'b0);
    issue_op(KIND_READ, 63, 63, 1'b1);
    issue_op(KIND_READ, 0, 1, 1'b0);
    issue_op(KIND_WRITE, 63, 63, 1'b0);
    issue_op(KIND_READ, 63, 63, 1'b0);
    issue_op(KIND_UNUSED, 0, 0, 1'b0);
    issue_op(KIND_UNUSED, 63, 63, 1'b1);
    issue_op(KIND_READ, 0, 0, 1'b0);
    // Lone cell starves on the next generation
    issue_op(KIND_STEP, 0, 0, 1'b0);
    issue_op(KIND_READ, 0, 0, 1'b0);
    // Blinker straddling the column wrap; it must flip into the row wrap
    issue_op(KIND_WRITE, 0, 63, 1'b1);
    issue_op(KIND_WRITE, 0, 0, 1'b1);
    issue_op(KIND_WRITE, 0, 1, 1'b1);
    issue_op(KIND_STEP, 0, 0, 1'b0);
    issue_op(KIND_READ, 63, 0, 1'b0);
    issue_op(KIND_READ, 0, 0, 1'b0);
    issue_op(KIND_READ, 1, 0, 1'b0);
    issue_op(KIND_READ, 0, 63, 1'b0);
    issue_op(KIND_STEP, 0, 0, 1'b0);
    issue_op(KIND_READ, 0, 63, 1'b0);
    issue_op(KIND_READ, 63, 0, 1'b0);

    // Phases: a fixed list of settings first (tiny grids, out-of-range sizes,
    // full masks, named rule sets), then random settings, mostly small grids.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:  begin rows_data = 9'd8;   cols_data = 9'd8;   birth_data = 9'd8;   survive_data = 9'd12;  end
        1:  begin rows_data = 9'd1;   cols_data = 9'd1;   birth_data = 9'd2;   survive_data = 9'd2;   end
        2:  begin rows_data = 9'd2;   cols_data = 9'd2;   birth_data = 9'd24;  survive_data = 9'd24;  end
        3:  begin rows_data = 9'd0;   cols_data = 9'd0;   birth_data = 9'd511; survive_data = 9'd511; end
        4:  begin rows_data = 9'd3;   cols_data = 9'd64;  birth_data = 9'd496; survive_data = 9'd60;  end
        5:  begin rows_data = 9'd64;  cols_data = 9'd3;   pick_rule(birth_data, survive_data);    end
        6:  begin rows_data = 9'h1FF; cols_data = 9'h1FF; birth_data = 9'd0;   survive_data = 9'd0;   end
        7:  begin rows_data = 9'd2;   cols_data = 9'd5;   pick_rule(birth_data, survive_data);    end
        8:  begin rows_data = 9'd5;   cols_data = 9'd1;   pick_rule(birth_data, survive_data);    end
        9:  begin rows_data = 9'd16;  cols_data = 9'd16;  birth_data = 9'd8;   survive_data = 9'd12;  end
        10: begin rows_data = 9'd65;  cols_data = 9'd7;   birth_data = 9'd8;   survive_data = 9'd12;  end
        default: begin
          case ($urandom_range(0, 9))
            0:       rows_data = CFG_DATA_W'($urandom_range(0, 511));
            1:       rows_data = 9'd64;
            default: rows_data = CFG_DATA_W'($urandom_range(1, 10));
          endcase
          case ($urandom_range(0, 9))
            0:       cols_data = CFG_DATA_W'($urandom_range(0, 511));
            1:       cols_data = 9'd64;
            default: cols_data = CFG_DATA_W'($urandom_range(1, 10));
          endcase
          pick_rule(birth_data, survive_data);
        end
      endcase

      // Registers change only with the block idle
      settle_block();
      write_register(CFG_ROWS_USED, rows_data);
      write_register(CFG_COLS_USED, cols_data);
      write_register(CFG_BIRTH_MASK, birth_data);
      write_register(CFG_SURVIVE_MASK, survive_data);
      nr = grid_extent(rows_data);
      nc = grid_extent(cols_data);
      items_left = $urandom_range(38, 50);

      // Seed a random population inside the used area
      repeat ($urandom_range(4, 14)) begin
        issue_op(KIND_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                 ($urandom_range(0, 3) != 0));
        items_left--;
      end

      // Evolve and probe: generations, reads, edits, a little noise
      while (items_left > 0) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 6) == 0) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end else begin
          r = $urandom_range(0, nr - 1);
          c = $urandom_range(0, nc - 1);
        end
        if (pick < 14) begin
          issue_op(KIND_STEP, r, c, 1'($urandom_range(0, 1)));
          items_left--;
        end else if (pick < 66) begin
          issue_op(KIND_READ, r, c, 1'($urandom_range(0, 1)));
          items_left--;
        end else if (pick < 94) begin
          issue_op(KIND_WRITE, r, c, 1'($urandom_range(0, 1)));
          items_left--;
        end else begin
          issue_op(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)));
        end

        // Stall the result side for a long stretch while items keep coming
        if (items_left == 20 && phase % 4 == 2)
          hold_requests++;
        // Pause the sender until every read has been answered
        if (items_left == 15 && phase % 4 == 1)
          drain_results();
      end
    end

    // Wait for the last results and any generation still running
    settle_block();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
